### rtl/core/hbs_pkg.sv
package hbs_pkg;

   localparam int DEF_BINS        = 32;
   localparam int DEF_MAX_SAMPLES = 1048575;

   localparam int SAMPLE_W = 32;
   localparam int FRAC_W   = 16;
   localparam int BCFG_W   = 6;
   localparam int CNT_W    = 20;
   localparam int SIGMA_W  = 31;
   localparam int OUT_W    = 192;
   localparam int QDEPTH   = 4;

   localparam logic [CNT_W-1:0]          CNT_MAX   = '1;
   localparam logic [SIGMA_W-1:0]        SIGMA_MAX = '1;
   localparam logic signed [SAMPLE_W-1:0] ONE_Q16  = 32'sd65536;

   localparam logic signed [SAMPLE_W-1:0] LOW_RESET    = '0;
   localparam logic signed [SAMPLE_W-1:0] HIGH_RESET   = ONE_Q16;
   localparam logic [BCFG_W-1:0]          BCOUNT_RESET = 6'd32;

   typedef enum logic [1:0] {
      CSR_LOW_EDGE,
      CSR_HIGH_EDGE,
      CSR_BIN_COUNT
   } csr_index_type;

   typedef enum logic [0:0] {
      KIND_BIN   = 1'b0,
      KIND_STATS = 1'b1
   } rsp_kind_type;

   typedef enum logic [2:0] {
      F_IDLE,
      F_PREP,
      F_CHECK,
      F_DIV,
      F_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_INC,
      B_EMIT_RD,
      B_EMIT_OUT,
      B_STATS
   } back_state_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL_NS2,
      S_MUL_S1,
      S_MUL_D,
      S_DIV_MEAN,
      S_DIV_SIG,
      S_SQRT,
      S_DONE
   } stats_state_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic full;
      logic empty;
   } queue_status_type;

endpackage

### rtl/core/hbs_front.sv
module hbs_front import hbs_pkg::*; #(
   parameter  int BINS  = DEF_BINS,
   localparam int CW    = $clog2(BINS + 1),
   localparam int IW    = (BINS > 1) ? $clog2(BINS) : 1,
   localparam int ENT_W = 1 + CW + 2 * SAMPLE_W + SAMPLE_W + IW + 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       req_final,
   input  logic signed [SAMPLE_W-1:0] low_edge,
   input  logic signed [SAMPLE_W-1:0] high_edge,
   input  logic [BCFG_W-1:0]          bin_count,
   output logic                       push,
   output logic [ENT_W-1:0]           push_data,
   input  logic                       full
);

   localparam int NUMW = 33 + CW;
   localparam int SW   = (IW > 1) ? $clog2(IW) : 1;

   front_state_type state_ff, state_in;

   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic signed [SAMPLE_W-1:0] low_ff, low_in, high_ff, high_in;
   logic                       final_ff, final_in;
   logic [CW-1:0]              cnt_ff, cnt_in;
   logic [NUMW-1:0]            num_ff, num_in, cden_ff, cden_in;
   logic [SAMPLE_W-1:0]        den_ff, den_in;
   logic [2*SAMPLE_W-1:0]      sq_ff, sq_in;
   logic                       below_ff, below_in, top_ff, top_in, wide_ff, wide_in;
   logic [15:0]                k16_ff, k16_in;
   logic [SW-1:0]              step_ff, step_in;
   logic [IW-1:0]              idx_ff, idx_in;
   logic                       inside_ff, inside_in;

   logic signed [SAMPLE_W:0]   diff, span;
   logic [SAMPLE_W-1:0]        mag;
   logic [NUMW-1:0]            den_sh;
   logic [BCFG_W-1:0]          clamped;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      low_ff    <= low_in;
      high_ff   <= high_in;
      final_ff  <= final_in;
      cnt_ff    <= cnt_in;
      num_ff    <= num_in;
      cden_ff   <= cden_in;
      den_ff    <= den_in;
      sq_ff     <= sq_in;
      below_ff  <= below_in;
      top_ff    <= top_in;
      wide_ff   <= wide_in;
      k16_ff    <= k16_in;
      step_ff   <= step_in;
      idx_ff    <= idx_in;
      inside_ff <= inside_in;
   end

   always_comb begin
      state_in  = state_ff;
      sample_in = sample_ff;
      low_in    = low_ff;
      high_in   = high_ff;
      final_in  = final_ff;
      cnt_in    = cnt_ff;
      num_in    = num_ff;
      cden_in   = cden_ff;
      den_in    = den_ff;
      sq_in     = sq_ff;
      below_in  = below_ff;
      top_in    = top_ff;
      wide_in   = wide_ff;
      k16_in    = k16_ff;
      step_in   = step_ff;
      idx_in    = idx_ff;
      inside_in = inside_ff;
      req_tready = 1'b0;
      push       = 1'b0;

      diff   = {sample_ff[SAMPLE_W-1], sample_ff} - {low_ff[SAMPLE_W-1], low_ff};
      span   = {high_ff[SAMPLE_W-1], high_ff} - {low_ff[SAMPLE_W-1], low_ff};
      mag    = sample_ff[SAMPLE_W-1] ? (~sample_ff + 1'b1) : sample_ff;
      den_sh = NUMW'(den_ff) << step_ff;

      clamped = bin_count;
      if (bin_count == '0) begin
         clamped = BCFG_W'(1);
      end else if (bin_count > BCFG_W'(BINS)) begin
         clamped = BCFG_W'(BINS);
      end

      unique case (state_ff)
         F_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               sample_in = req_sample;
               final_in  = req_final;
               low_in    = low_edge;
               high_in   = high_edge;
               cnt_in    = CW'(clamped);
               state_in  = F_PREP;
            end
         end
         F_PREP: begin
            num_in   = NUMW'(diff[SAMPLE_W-1:0]) * NUMW'(cnt_ff);
            cden_in  = NUMW'(span[SAMPLE_W-1:0]) * NUMW'(cnt_ff);
            den_in   = span[SAMPLE_W-1:0];
            sq_in    = mag * mag;
            below_in = diff[SAMPLE_W];
            top_in   = (sample_ff == high_ff);
            wide_in  = !span[SAMPLE_W] && (span != '0);
            k16_in   = diff[SAMPLE_W-1:FRAC_W];
            state_in = F_CHECK;
         end
         F_CHECK: begin
            idx_in = '0;
            priority if (top_ff) begin
               inside_in = 1'b1;
               idx_in    = IW'(cnt_ff - 1'b1);
               state_in  = F_PUSH;
            end else if (below_ff) begin
               inside_in = 1'b0;
               state_in  = F_PUSH;
            end else if (!wide_ff) begin
               inside_in = (k16_ff < 16'(cnt_ff));
               idx_in    = IW'(k16_ff);
               state_in  = F_PUSH;
            end else if (num_ff >= cden_ff) begin
               inside_in = 1'b0;
               state_in  = F_PUSH;
            end else begin
               inside_in = 1'b1;
               step_in   = SW'(IW - 1);
               state_in  = F_DIV;
            end
         end
         F_DIV: begin
            if (num_ff >= den_sh) begin
               num_in          = num_ff - den_sh;
               idx_in[step_ff] = 1'b1;
            end
            if (step_ff == '0) begin
               state_in = F_PUSH;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         F_PUSH: begin
            if (!full) begin
               push     = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   assign push_data = {final_ff, cnt_ff, sq_ff, sample_ff, idx_ff, inside_ff};

endmodule

### rtl/core/hbs_queue.sv
module hbs_queue import hbs_pkg::*; #(
   parameter int W     = 8,
   parameter int DEPTH = QDEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] push_data,
   input  logic         pop,
   output logic [W-1:0] pop_data,
   output logic         full,
   output logic         empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [W-1:0]  mem [DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] count_ff, count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= push_data;
      end
   end

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign pop_data = mem[rd_ff];
   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);

endmodule

### rtl/core/hbs_stats.sv
module hbs_stats import hbs_pkg::*; #(
   parameter  int MAX_SAMPLES = DEF_MAX_SAMPLES,
   localparam int NW   = $clog2(MAX_SAMPLES + 1),
   localparam int SUMW = SAMPLE_W + NW,
   localparam int SQW  = 62 + NW
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic signed [SUMW-1:0]     sum_in,
   input  logic [SQW-1:0]             sq_in,
   input  logic [NW-1:0]              n_in,
   output logic                       done,
   output logic signed [SAMPLE_W-1:0] mean,
   output logic [SIGMA_W-1:0]         sigma
);

   localparam int PW = 63 + 2 * NW;
   localparam int DW = 2 * NW;
   localparam int MB = 31 + NW;

   stats_state_type state_ff, state_in;

   logic [PW-1:0]   ma_ff, ma_in, mp_ff, mp_in, ns2_ff, ns2_in, num_ff, num_in;
   logic [MB-1:0]   mb_ff, mb_in;
   logic [DW-1:0]   d_ff, d_in, rem_ff, rem_in;
   logic [63:0]     dvd_ff, dvd_in, q_ff, q_in;
   logic [63:0]     sx_ff, sx_in, sr_ff, sr_in, sb_ff, sb_in;
   logic [6:0]      it_ff, it_in;
   logic signed [SAMPLE_W-1:0] mean_ff, mean_in;
   logic [SIGMA_W-1:0]         sigma_ff, sigma_in;

   logic [MB-1:0]   s1m;
   logic            mul_end;
   logic [DW-1:0]   den;
   logic [DW:0]     sh;
   logic [63:0]     mq, sq_t;
   logic [PW-65:0]  num_hi;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      ma_ff    <= ma_in;
      mb_ff    <= mb_in;
      mp_ff    <= mp_in;
      ns2_ff   <= ns2_in;
      num_ff   <= num_in;
      d_ff     <= d_in;
      rem_ff   <= rem_in;
      dvd_ff   <= dvd_in;
      q_ff     <= q_in;
      sx_ff    <= sx_in;
      sr_ff    <= sr_in;
      sb_ff    <= sb_in;
      it_ff    <= it_in;
      mean_ff  <= mean_in;
      sigma_ff <= sigma_in;
   end

   always_comb begin
      state_in = state_ff;
      ma_in    = ma_ff;
      mb_in    = mb_ff;
      mp_in    = mp_ff;
      ns2_in   = ns2_ff;
      num_in   = num_ff;
      d_in     = d_ff;
      rem_in   = rem_ff;
      dvd_in   = dvd_ff;
      q_in     = q_ff;
      sx_in    = sx_ff;
      sr_in    = sr_ff;
      sb_in    = sb_ff;
      it_in    = it_ff;
      mean_in  = mean_ff;
      sigma_in = sigma_ff;

      s1m     = sum_in[SUMW-1] ? MB'(-sum_in) : MB'(sum_in);
      mul_end = (mb_ff == '0);
      den     = (state_ff == S_DIV_MEAN) ? DW'(n_in) : d_ff;
      sh      = {rem_ff, dvd_ff[63]};
      sq_t    = sr_ff + sb_ff;
      num_hi  = num_ff[PW-1:64];
      mq      = '0;

      // shift-add multiply step
      if (state_ff == S_MUL_NS2 || state_ff == S_MUL_S1 || state_ff == S_MUL_D) begin
         if (mb_ff[0]) begin
            mp_in = mp_ff + ma_ff;
         end
         ma_in = ma_ff << 1;
         mb_in = mb_ff >> 1;
      end

      // restoring divide step
      if (state_ff == S_DIV_MEAN || state_ff == S_DIV_SIG) begin
         if (sh >= {1'b0, den}) begin
            rem_in = DW'(sh - {1'b0, den});
            q_in   = {q_ff[62:0], 1'b1};
         end else begin
            rem_in = DW'(sh);
            q_in   = {q_ff[62:0], 1'b0};
         end
         dvd_in = dvd_ff << 1;
         it_in  = it_ff + 1'b1;
      end

      unique case (state_ff)
         S_IDLE, S_DONE: begin
            if (start) begin
               ma_in    = PW'(sq_in);
               mb_in    = MB'(n_in);
               mp_in    = '0;
               state_in = S_MUL_NS2;
            end
         end
         S_MUL_NS2: begin
            if (mul_end) begin
               ns2_in   = mp_ff;
               ma_in    = PW'(s1m);
               mb_in    = s1m;
               mp_in    = '0;
               state_in = S_MUL_S1;
            end
         end
         S_MUL_S1: begin
            if (mul_end) begin
               num_in   = ns2_ff - mp_ff;
               ma_in    = PW'(n_in);
               mb_in    = MB'(n_in - 1'b1);
               mp_in    = '0;
               state_in = S_MUL_D;
            end
         end
         S_MUL_D: begin
            if (mul_end) begin
               d_in     = DW'(mp_ff);
               rem_in   = '0;
               dvd_in   = 64'(s1m);
               q_in     = '0;
               it_in    = '0;
               state_in = S_DIV_MEAN;
            end
         end
         S_DIV_MEAN: begin
            if (it_ff == 7'd63) begin
               mq = q_in + 64'(rem_in != '0);
               mean_in = sum_in[SUMW-1] ? SAMPLE_W'(~mq + 1'b1) : SAMPLE_W'(q_in);
               if (n_in <= NW'(1)) begin
                  sigma_in = '0;
                  state_in = S_DONE;
               end else if (DW'(num_hi) >= d_ff) begin
                  sigma_in = SIGMA_MAX;
                  state_in = S_DONE;
               end else begin
                  rem_in   = DW'(num_hi);
                  dvd_in   = num_ff[63:0];
                  q_in     = '0;
                  it_in    = '0;
                  state_in = S_DIV_SIG;
               end
            end
         end
         S_DIV_SIG: begin
            if (it_ff == 7'd63) begin
               sx_in    = q_in;
               sr_in    = '0;
               sb_in    = 64'h4000_0000_0000_0000;
               it_in    = '0;
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            if (sx_ff >= sq_t) begin
               sx_in = sx_ff - sq_t;
               sr_in = (sr_ff >> 1) + sb_ff;
            end else begin
               sr_in = sr_ff >> 1;
            end
            sb_in = sb_ff >> 2;
            it_in = it_ff + 1'b1;
            if (it_ff == 7'd31) begin
               sigma_in = (sr_in > 64'(SIGMA_MAX)) ? SIGMA_MAX : SIGMA_W'(sr_in);
               state_in = S_DONE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign done  = (state_ff == S_DONE);
   assign mean  = mean_ff;
   assign sigma = sigma_ff;

endmodule

### rtl/core/hbs_back.sv
module hbs_back import hbs_pkg::*; #(
   parameter  int BINS        = DEF_BINS,
   parameter  int MAX_SAMPLES = DEF_MAX_SAMPLES,
   localparam int CW    = $clog2(BINS + 1),
   localparam int IW    = (BINS > 1) ? $clog2(BINS) : 1,
   localparam int ENT_W = 1 + CW + 2 * SAMPLE_W + SAMPLE_W + IW + 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              empty,
   output logic              pop,
   input  logic [ENT_W-1:0]  pop_data,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [OUT_W-1:0]  rsp_tdata,
   output logic              rsp_tuser,
   output logic              rsp_tlast
);

   localparam int NW   = $clog2(MAX_SAMPLES + 1);
   localparam int SUMW = SAMPLE_W + NW;
   localparam int SQW  = 62 + NW;
   localparam int CMW  = (NW > CNT_W) ? NW : CNT_W;

   back_state_type state_ff, state_in;

   logic [CNT_W-1:0]           mem [BINS];
   logic [BINS-1:0]            valid_ff, valid_in;
   logic [CNT_W-1:0]           rd_data_ff;
   logic                       rd_valid_ff;
   logic [IW-1:0]              rd_addr, wr_addr;
   logic                       wr_en;
   logic [CNT_W-1:0]           wr_data;

   logic [NW-1:0]              n_ff, n_in;
   logic [CNT_W-1:0]           outside_ff, outside_in;
   logic signed [SAMPLE_W-1:0] min_ff, min_in, max_ff, max_in;
   logic signed [SUMW-1:0]     sum_ff, sum_in;
   logic [SQW-1:0]             sq_ff, sq_in;

   logic [IW-1:0]              idx_ff, idx_in, eb_ff, eb_in;
   logic                       fin_ff, fin_in;
   logic [CW-1:0]              cnt_ff, cnt_in;

   logic                       ovalid_ff, ovalid_in, okind_ff, okind_in;
   logic [OUT_W-1:0]           odata_ff, odata_in;

   logic                       e_final, e_inside;
   logic [CW-1:0]              e_cnt;
   logic [2*SAMPLE_W-1:0]      e_sq;
   logic signed [SAMPLE_W-1:0] e_sample;
   logic [IW-1:0]              e_idx;

   logic                       out_free, st_start, st_done;
   logic signed [SAMPLE_W-1:0] st_mean;
   logic [SIGMA_W-1:0]         st_sigma;
   logic [CMW-1:0]             n_ext;
   logic [CNT_W-1:0]           n_sat, bin_val;
   logic [4:0]                 bin_no;

   assign {e_final, e_cnt, e_sq, e_sample, e_idx, e_inside} = pop_data;

   hbs_stats #(.MAX_SAMPLES(MAX_SAMPLES)) u_stats (
      .clock  (clock),
      .reset  (reset),
      .start  (st_start),
      .sum_in (sum_ff),
      .sq_in  (sq_ff),
      .n_in   (n_ff),
      .done   (st_done),
      .mean   (st_mean),
      .sigma  (st_sigma)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= B_IDLE;
         valid_ff   <= '0;
         n_ff       <= '0;
         outside_ff <= '0;
         sum_ff     <= '0;
         sq_ff      <= '0;
         ovalid_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         valid_ff   <= valid_in;
         n_ff       <= n_in;
         outside_ff <= outside_in;
         sum_ff     <= sum_in;
         sq_ff      <= sq_in;
         ovalid_ff  <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      min_ff      <= min_in;
      max_ff      <= max_in;
      idx_ff      <= idx_in;
      eb_ff       <= eb_in;
      fin_ff      <= fin_in;
      cnt_ff      <= cnt_in;
      okind_ff    <= okind_in;
      odata_ff    <= odata_in;
      rd_data_ff  <= mem[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_comb begin
      state_in   = state_ff;
      valid_in   = valid_ff;
      n_in       = n_ff;
      outside_in = outside_ff;
      sum_in     = sum_ff;
      sq_in      = sq_ff;
      min_in     = min_ff;
      max_in     = max_ff;
      idx_in     = idx_ff;
      eb_in      = eb_ff;
      fin_in     = fin_ff;
      cnt_in     = cnt_ff;
      okind_in   = okind_ff;
      odata_in   = odata_ff;
      ovalid_in  = ovalid_ff && !rsp_tready;
      pop        = 1'b0;
      rd_addr    = eb_ff;
      wr_addr    = idx_ff;
      wr_en      = 1'b0;
      wr_data    = '0;
      out_free   = !ovalid_ff || rsp_tready;
      st_start   = (state_ff == B_EMIT_RD) && (eb_ff == '0);

      n_ext   = CMW'(n_ff);
      n_sat   = (n_ext > CMW'(CNT_MAX)) ? CNT_MAX : CNT_W'(n_ext);
      bin_val = rd_valid_ff ? rd_data_ff : '0;
      bin_no  = 5'(eb_ff);

      unique case (state_ff)
         B_IDLE: begin
            rd_addr = e_idx;
            if (!empty) begin
               pop = 1'b1;
               if (n_ff == '0) begin
                  min_in = e_sample;
                  max_in = e_sample;
               end else begin
                  if (e_sample < min_ff) min_in = e_sample;
                  if (e_sample > max_ff) max_in = e_sample;
               end
               if (n_ff < NW'(MAX_SAMPLES)) begin
                  n_in   = n_ff + 1'b1;
                  sum_in = sum_ff + SUMW'(e_sample);
                  sq_in  = sq_ff + SQW'(e_sq);
               end
               if (!e_inside && outside_ff != CNT_MAX) begin
                  outside_in = outside_ff + 1'b1;
               end
               idx_in = e_idx;
               fin_in = e_final;
               cnt_in = e_cnt;
               eb_in  = '0;
               if (e_inside) begin
                  state_in = B_INC;
               end else if (e_final) begin
                  state_in = B_EMIT_RD;
               end
            end
         end
         B_INC: begin
            wr_en   = 1'b1;
            wr_data = !rd_valid_ff ? CNT_W'(1) :
                      (rd_data_ff == CNT_MAX) ? CNT_MAX : rd_data_ff + 1'b1;
            valid_in[idx_ff] = 1'b1;
            state_in = fin_ff ? B_EMIT_RD : B_IDLE;
         end
         B_EMIT_RD: begin
            state_in = B_EMIT_OUT;
         end
         B_EMIT_OUT: begin
            if (out_free) begin
               ovalid_in = 1'b1;
               okind_in  = KIND_BIN;
               odata_in  = OUT_W'({bin_val, bin_no});
               if (CW'(eb_ff) == cnt_ff - 1'b1) begin
                  state_in = B_STATS;
               end else begin
                  eb_in    = eb_ff + 1'b1;
                  state_in = B_EMIT_RD;
               end
            end
         end
         B_STATS: begin
            if (st_done && out_free) begin
               ovalid_in  = 1'b1;
               okind_in   = KIND_STATS;
               odata_in   = {st_sigma, st_mean, max_ff, min_ff, outside_ff, n_sat,
                             CNT_W'(0), 5'd0};
               valid_in   = '0;
               n_in       = '0;
               outside_in = '0;
               sum_in     = '0;
               sq_in      = '0;
               state_in   = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = odata_ff;
   assign rsp_tuser  = okind_ff;
   assign rsp_tlast  = okind_ff;

endmodule

### rtl/core/histogram_binning_with_statistics_core.sv
// Histogram with batch statistics over signed Q16.16 samples.
// req_*: one sample per transaction, tlast marks the last sample of a batch.
// rsp_*: after the last sample, one bin transaction per bin in use
//   (tuser = 0), then one statistics transaction (tuser = 1, tlast = 1).
// csr_*: write low edge, high edge and bin count while the block is idle.
// Front end: prepare and check states per sample, plus clog2(BINS)
//   divider steps when it lands between the edges, then a push; the next
//   sample is taken only after that push. A 4-entry queue feeds the back end.
// Back end: pops a sample and, when it is inside, increments its bin counter
//   in a further state (read-modify-write of the bin memory). After the last
//   sample, each bin is read and then sent. Statistics come from a serial unit
//   (shift-add multiplies, two 64-step divides, a 32-step square root)
//   started at the first bin read; the statistics transaction trails the bins.
// Reset clears counters, bin valid bits and state; no clearing pass is needed.
// A stalled rsp_tready holds the output register and, once the queue fills,
//   backpressures req_tready.
module histogram_binning_with_statistics_core import hbs_pkg::*; #(
   parameter int BINS        = DEF_BINS,
   parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [SAMPLE_W-1:0] req_tdata,   // sample
   input  logic                req_tlast,   // final_sample
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [OUT_W-1:0]    rsp_tdata,   // bin_index, bin_total, samples, outside,
                                            // least, greatest, mean, sigma
   output logic                rsp_tuser,   // kind
   output logic                rsp_tlast,   // last
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [SAMPLE_W-1:0] csr_wdata
);

   localparam int CW    = $clog2(BINS + 1);
   localparam int IW    = (BINS > 1) ? $clog2(BINS) : 1;
   localparam int ENT_W = 1 + CW + 2 * SAMPLE_W + SAMPLE_W + IW + 1;

   logic signed [SAMPLE_W-1:0] low_ff, low_in, high_ff, high_in;
   logic [BCFG_W-1:0]          bcount_ff, bcount_in;
   logic [ENT_W-1:0]           q_wdata, q_rdata;
   queue_status_type           q;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff    <= LOW_RESET;
         high_ff   <= HIGH_RESET;
         bcount_ff <= BCOUNT_RESET;
      end else begin
         low_ff    <= low_in;
         high_ff   <= high_in;
         bcount_ff <= bcount_in;
      end
   end

   always_comb begin
      low_in    = low_ff;
      high_in   = high_ff;
      bcount_in = bcount_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_LOW_EDGE:  low_in    = csr_wdata;
            CSR_HIGH_EDGE: high_in   = csr_wdata;
            CSR_BIN_COUNT: bcount_in = csr_wdata[BCFG_W-1:0];
            default: ;
         endcase
      end
   end

   hbs_front #(.BINS(BINS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_sample (req_tdata),
      .req_final  (req_tlast),
      .low_edge   (low_ff),
      .high_edge  (high_ff),
      .bin_count  (bcount_ff),
      .push       (q.push),
      .push_data  (q_wdata),
      .full       (q.full)
   );

   hbs_queue #(.W(ENT_W), .DEPTH(QDEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q.push),
      .push_data (q_wdata),
      .pop       (q.pop),
      .pop_data  (q_rdata),
      .full      (q.full),
      .empty     (q.empty)
   );

   hbs_back #(.BINS(BINS), .MAX_SAMPLES(MAX_SAMPLES)) u_back (
      .clock      (clock),
      .reset      (reset),
      .empty      (q.empty),
      .pop        (q.pop),
      .pop_data   (q_rdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q.push |-> !q.full) else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q.pop |-> !q.empty) else $error("queue read while empty");

   a_last_is_stats: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser) else $error("tlast on a bin transaction");

   a_stats_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast) else $error("statistics without tlast");

endmodule

### dv/hbs_checker.sv
module hbs_checker import hbs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tready,
   input  logic [SAMPLE_W-1:0] req_tdata,
   input  logic                req_tlast,
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic [OUT_W-1:0]    rsp_tdata,
   input  logic                rsp_tuser,
   input  logic                rsp_tlast,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [SAMPLE_W-1:0] csr_wdata,
   output int                  errors,
   output int                  pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [SIGMA_W-1:0]         sigma;
      logic signed [SAMPLE_W-1:0] mean;
      logic signed [SAMPLE_W-1:0] greatest;
      logic signed [SAMPLE_W-1:0] least;
      logic [CNT_W-1:0]           outside;
      logic [CNT_W-1:0]           samples;
      logic [CNT_W-1:0]           bin_total;
      logic [4:0]                 bin_index;
   } rsp_fields_t;

   typedef struct {
      rsp_kind_type kind;
      rsp_fields_t  f;
      logic         last;
   } hist_result_t;

   hist_result_t    hist_results_q[$];

   longint          low_edge_r, high_edge_r;
   logic [5:0]      bin_count_r;
   logic [CNT_W-1:0] bin_tally[DEF_BINS];
   logic [CNT_W-1:0] n_count, out_count;
   logic signed [31:0] run_min, run_max;
   longint          run_sum;
   logic [127:0]    sq_sum;

   assign pending = hist_results_q.size();

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH %0t %s: got %0h expected %0h", $time, what, got, want);
      errors++;
   endtask

   function automatic logic [63:0] int_sqrt(logic [63:0] x);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   task automatic clear_batch();
      for (int i = 0; i < DEF_BINS; i++) bin_tally[i] = '0;
      n_count = '0;
      out_count = '0;
      run_min = '0;
      run_max = '0;
      run_sum = 0;
      sq_sum = '0;
   endtask

   task automatic bin_sample(logic signed [31:0] s, logic fin);
      longint v, k, q, cnt;
      logic [63:0] mag, sig, dq;
      logic [127:0] num, nn;
      hist_result_t r;
      v = s;
      cnt = (bin_count_r < 1) ? 1 : (bin_count_r > DEF_BINS) ? DEF_BINS : bin_count_r;
      if (n_count == 0) begin
         run_min = s;
         run_max = s;
      end else begin
         if (s < run_min) run_min = s;
         if (s > run_max) run_max = s;
      end
      if (n_count < DEF_MAX_SAMPLES) begin
         mag = (v < 0) ? -v : v;
         n_count++;
         run_sum += v;
         sq_sum += 128'(mag) * 128'(mag);
      end
      if (v < low_edge_r) k = -1;
      else if (high_edge_r > low_edge_r)
         k = ((v - low_edge_r) * cnt) / (high_edge_r - low_edge_r);
      else k = (v - low_edge_r) / 65536;
      if (v == high_edge_r) k = cnt - 1;
      if (k >= 0 && k < cnt) begin
         if (bin_tally[k] != CNT_MAX) bin_tally[k]++;
      end else if (out_count != CNT_MAX) begin
         out_count++;
      end
      if (!fin) return;
      for (int b = 0; b < cnt; b++) begin
         r.kind = KIND_BIN;
         r.f = '0;
         r.f.bin_index = b[4:0];
         r.f.bin_total = bin_tally[b];
         r.last = 1'b0;
         hist_results_q.push_back(r);
      end
      q = run_sum / longint'(n_count);
      if (q * longint'(n_count) != run_sum && run_sum < 0) q--;
      sig = 0;
      if (n_count > 1) begin
         mag = (run_sum < 0) ? -run_sum : run_sum;
         num = 128'(n_count) * sq_sum - 128'(mag) * 128'(mag);
         nn = num / (128'(n_count) * 128'(n_count - 1));
         dq = (nn[127:64] != 0) ? '1 : nn[63:0];
         sig = int_sqrt(dq);
         if (sig > 64'h7FFF_FFFF) sig = 64'h7FFF_FFFF;
      end
      r.kind = KIND_STATS;
      r.f = '0;
      r.f.samples = n_count;
      r.f.outside = out_count;
      r.f.least = run_min;
      r.f.greatest = run_max;
      r.f.mean = q[31:0];
      r.f.sigma = sig[30:0];
      r.last = 1'b1;
      hist_results_q.push_back(r);
      clear_batch();
   endtask

   task automatic check_result();
      hist_result_t w;
      rsp_fields_t g;
      if (hist_results_q.size() == 0) begin
         $display("MISMATCH %0t: unexpected result transaction", $time);
         errors++;
         return;
      end
      w = hist_results_q.pop_front();
      g = rsp_tdata;
      if (rsp_tuser != w.kind) report("kind", rsp_tuser, w.kind);
      if (rsp_tlast != w.last) report("last", rsp_tlast, w.last);
      if (g.bin_index != w.f.bin_index) report("bin_index", g.bin_index, w.f.bin_index);
      if (g.bin_total != w.f.bin_total) report("bin_total", g.bin_total, w.f.bin_total);
      if (g.samples != w.f.samples) report("samples", g.samples, w.f.samples);
      if (g.outside != w.f.outside) report("outside", g.outside, w.f.outside);
      if (g.least != w.f.least) report("least", g.least, w.f.least);
      if (g.greatest != w.f.greatest) report("greatest", g.greatest, w.f.greatest);
      if (g.mean != w.f.mean) report("mean", g.mean, w.f.mean);
      if (g.sigma != w.f.sigma) report("sigma", g.sigma, w.f.sigma);
   endtask

   initial errors = 0;

   always @(posedge clock) begin
      if (reset) begin
         low_edge_r = longint'(LOW_RESET);
         high_edge_r = longint'(HIGH_RESET);
         bin_count_r = BCOUNT_RESET;
         clear_batch();
         hist_results_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_LOW_EDGE:  low_edge_r = longint'($signed(csr_wdata));
               CSR_HIGH_EDGE: high_edge_r = longint'($signed(csr_wdata));
               CSR_BIN_COUNT: bin_count_r = csr_wdata[5:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) bin_sample(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) check_result();
      end
   end
endmodule

### dv/histogram_binning_with_statistics_core_tb.sv
module histogram_binning_with_statistics_core_tb;
   import hbs_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic                clock = 0;
   logic                reset = 1;
   logic                req_tvalid = 0;
   logic                req_tready;
   logic [SAMPLE_W-1:0] req_tdata = '0;
   logic                req_tlast = 0;
   logic                rsp_tvalid;
   logic                rsp_tready = 0;
   logic [OUT_W-1:0]    rsp_tdata;
   logic                rsp_tuser;
   logic                rsp_tlast;
   logic                csr_we = 0;
   logic [1:0]          csr_index = CSR_LOW_EDGE;
   logic [SAMPLE_W-1:0] csr_wdata = '0;
   int                  errors, pending;
   int                  cycles = 0;
   int                  batches = 0, sent = 0;
   bit                  quiet = 0, hold_req = 0;
   longint              cur_low = 0, cur_high = 65536;

   always #1 clock = ~clock;

   histogram_binning_with_statistics_core uut (.*);

   hbs_checker chk (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("histogram_binning_with_statistics_core verification failed");
         $finish;
      end
   end

   initial begin
      @(negedge reset);
      forever begin
         if (hold_req) begin
            rsp_tready <= 0;
            hold_req = 0;
            repeat (600) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end
         rsp_tready <= 1;
         @(posedge clock);
      end
   end

   task automatic send_sample(logic [31:0] v, logic fin);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= v;
      req_tlast <= fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
      if (fin) batches++;
   endtask

   task automatic settle();
      req_tvalid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic set_edges(longint lo, longint hi, logic [5:0] cnt);
      settle();
      csr_we <= 1;
      csr_index <= CSR_LOW_EDGE;
      csr_wdata <= lo[31:0];
      @(posedge clock);
      csr_index <= CSR_HIGH_EDGE;
      csr_wdata <= hi[31:0];
      @(posedge clock);
      csr_index <= CSR_BIN_COUNT;
      csr_wdata <= {26'd0, cnt};
      @(posedge clock);
      csr_we <= 0;
      cur_low = lo;
      cur_high = hi;
   endtask

   function automatic logic [31:0] pick_sample();
      longint span;
      span = cur_high - cur_low + 1;
      if (span > 1 && $urandom_range(0, 3) != 0)
         return 32'(cur_low + longint'({$urandom, $urandom}) % span);
      if ($urandom_range(0, 1)) return 32'(cur_high);
      return $urandom;
   endfunction

   task automatic random_batch(int len);
      for (int i = 0; i < len; i++) send_sample(pick_sample(), i == len - 1);
   endtask

   initial begin
      longint lo, hi;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // default edges: boundaries, high edge, below low edge, above high edge
      send_sample(32'd0, 0);
      send_sample(32'd65536, 0);
      send_sample(32'hFFFF_FFFF, 0);
      send_sample(32'd32767, 0);
      send_sample(32'd65535, 1);
      send_sample(32'h8000_0000, 1);
      send_sample(32'h7FFF_FFFF, 1);
      send_sample(32'h8000_0000, 0);
      send_sample(32'h7FFF_FFFF, 1);
      // high edge not above low edge: unit-wide bins, zero bin count
      set_edges(-262144, -262144, 6'd0);
      send_sample(32'hFFFC_0000, 0);
      send_sample(32'hFFFC_FFFF, 0);
      send_sample(32'h0000_0000, 1);
      set_edges(0, -65536, 6'd4);
      send_sample(32'd0, 0);
      send_sample(32'd196608, 0);
      send_sample(32'd262144, 0);
      send_sample(32'hFFFF_0000, 1);
      set_edges(-2147483648, 2147483647, 6'd33);
      send_sample(32'h8000_0000, 0);
      send_sample(32'h7FFF_FFFF, 0);
      send_sample(32'h0000_0000, 1);
      set_edges(-2147483648, 2147483647, 6'd63);
      send_sample(32'h1234_5678, 0);
      send_sample(32'hDEAD_BEEF, 1);
      set_edges(-65536, 65536, 6'd1);
      send_sample(32'd65536, 0);
      send_sample(32'hFFFF_0000, 1);
      // random batches with random edges
      while (sent < 85) begin
         if ($urandom_range(0, 2) == 0) begin
            lo = longint'($signed($urandom));
            hi = ($urandom_range(0, 4) == 0) ? lo - $urandom_range(0, 65536)
                 : lo + $urandom_range(1, 2000000);
            if (hi > 2147483647) hi = 2147483647;
            if (hi < -2147483648) hi = -2147483648;
            set_edges(lo, hi, 6'($urandom_range(0, 40)));
         end
         random_batch($urandom_range(1, 8));
      end
      // output held off while a long batch fills the block
      set_edges(-1048576, 1048576, 6'd32);
      hold_req = 1;
      random_batch(30);
      quiet = 1;
      random_batch(12);
      random_batch(1);
      settle();
      $display("covered %0d samples in %0d batches, edge and bin count settings incl. extremes",
               sent, batches);
      if (errors == 0) begin
         $display("histogram_binning_with_statistics_core verification clean");
      end else begin
         $display("histogram_binning_with_statistics_core verification failed");
      end
      $finish;
   end
endmodule
